// ===== rtl/fpr_pkg.sv =====
package fpr_pkg;

   // Result codes reported on the response channel.
   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_OK       = 3'd1;
   localparam logic [2:0] EV_SUM_ERR  = 3'd2;
   localparam logic [2:0] EV_BAD_END  = 3'd3;
   localparam logic [2:0] EV_READ     = 3'd4;
   localparam logic [2:0] EV_OK_TRUNC = 3'd5;

   // Frame delimiters.
   localparam logic [7:0] START_BYTE = 8'h23;
   localparam logic [7:0] END_BYTE   = 8'h24;

   // Number of result words the response queue holds.
   localparam int QUEUE_DEPTH = 2;

   // Write request from the parser into the payload store.
   typedef struct packed {
      logic        en;
      logic [15:0] addr;
      logic [7:0]  data;
   } store_wr_type;

   // Outcome of one parsed byte.
   typedef struct packed {
      logic [2:0]  event_res;
      logic [15:0] frame_cmd;
      logic [15:0] frame_len;
   } parse_res_type;

   // One complete result word.
   typedef struct packed {
      logic [2:0]  event_res;
      logic [15:0] frame_cmd;
      logic [15:0] frame_len;
      logic [7:0]  read_data;
   } rsp_type;

endpackage

// ===== rtl/framed_packet_receiver_unit.sv =====
// Framed packet receiver.
// The req channel carries one word per accepted handshake: req_op low feeds
// req_rx_byte to the frame parser, req_op high reads the payload store at
// req_read_index. Frames are 0x23, command (2 bytes), length (2 bytes),
// payload, 8-bit additive sum and 0x24.
// Every accepted word yields exactly one word on the rsp channel, in order.
// A word passes through the store read stage, whose registered port supplies the
// read byte, and then enters the output queue before it shows on rsp_valid.
// One word per cycle is sustained while rsp_stall is low.
// Up to three words are held (one in the store read stage, two in the output
// queue), so rsp_stall does not reach req_stall combinationally; req_stall
// rises only when all three places are full.
// Reset clears the parser to hunting the start byte and empties the queue.
// Payload store contents are not cleared; reading an unwritten entry gives
// an undefined byte.
module framed_packet_receiver_unit #(
   parameter int PAYLOAD_DEPTH = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [7:0]  req_rx_byte,
   input  logic [8:0]  req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [15:0] rsp_frame_cmd,
   output logic [15:0] rsp_frame_len,
   output logic [7:0]  rsp_read_data
);

   localparam int          AW      = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
   localparam logic [16:0] DEPTH_W = 17'(PAYLOAD_DEPTH);

   fpr_pkg::store_wr_type  store_wr;
   fpr_pkg::parse_res_type parse_res;
   fpr_pkg::rsp_type       q_push_data;
   fpr_pkg::rsp_type       q_head;
   logic [1:0]             q_count;

   logic        accept;
   logic        rd_en;
   logic        rd_in_range;
   logic [16:0] rd_index_ext;
   logic [7:0]  ram_rd_data;
   logic        s1_move;
   logic        q_pop;

   logic        s1_valid_ff;
   logic [2:0]  s1_event_ff;
   logic [15:0] s1_cmd_ff;
   logic [15:0] s1_len_ff;
   logic        s1_rd_sel_ff;

   // Input handshake, gated only by how many words are already held.
   assign req_stall = ({1'b0, q_count} + {2'b00, s1_valid_ff}) >= 3'd3;
   assign accept    = req_valid && !req_stall;

   // Store read request for a read word.
   assign rd_index_ext = {8'd0, req_read_index};
   assign rd_in_range  = rd_index_ext < DEPTH_W;
   assign rd_en        = accept && req_op && rd_in_range;

   fpr_parser #(
      .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .feed      (accept && !req_op),
      .rx_byte   (req_rx_byte),
      .store_wr  (store_wr),
      .parse_res (parse_res)
   );

   fpr_ram #(
      .WIDTH (8),
      .DEPTH (PAYLOAD_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr.en),
      .wr_addr (store_wr.addr[AW-1:0]),
      .wr_data (store_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_index_ext[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // The store read stage hands its word to the queue when there is room.
   assign q_pop   = rsp_valid && !rsp_stall;
   assign s1_move = s1_valid_ff && ((q_count < 2'(fpr_pkg::QUEUE_DEPTH)) || q_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_event_ff  <= req_op ? fpr_pkg::EV_READ : parse_res.event_res;
         s1_cmd_ff    <= req_op ? 16'd0 : parse_res.frame_cmd;
         s1_len_ff    <= req_op ? 16'd0 : parse_res.frame_len;
         s1_rd_sel_ff <= req_op && rd_in_range;
      end
   end

   // Assemble the result word with the store data.
   assign q_push_data = '{event_res: s1_event_ff, frame_cmd: s1_cmd_ff,
                          frame_len: s1_len_ff,
                          read_data: s1_rd_sel_ff ? ram_rd_data : 8'd0};

   fpr_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_move),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head      (q_head),
      .count     (q_count)
   );

   assign rsp_valid     = q_count != 2'd0;
   assign rsp_event_res = q_head.event_res;
   assign rsp_frame_cmd = q_head.frame_cmd;
   assign rsp_frame_len = q_head.frame_len;
   assign rsp_read_data = q_head.read_data;

   // A word blocked by a full queue keeps its place in the read stage.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && (q_count == 2'(fpr_pkg::QUEUE_DEPTH)) && rsp_stall
      |=> s1_valid_ff && $stable(s1_event_ff) && $stable(s1_rd_sel_ff))
      else $error("read stage word lost while the queue was full");

   // An accepted read word reaches the read stage as a read result.
   assert property (@(posedge clock) disable iff (reset)
      accept && req_op |=> s1_valid_ff && (s1_event_ff == fpr_pkg::EV_READ))
      else $error("read word not tracked in the read stage");

   // The store is never read and written in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(store_wr.en && rd_en))
      else $error("payload store read and write collide");

   // Only frame reports carry a command and length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_event_res == fpr_pkg::EV_NONE) || (rsp_event_res == fpr_pkg::EV_READ))
      |-> (rsp_frame_cmd == 16'd0) && (rsp_frame_len == 16'd0))
      else $error("command or length shown without a frame report");

endmodule

// ===== rtl/fpr_ram.sv =====
module fpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fpr_parser.sv =====
module fpr_parser #(
   parameter int PAYLOAD_DEPTH = 512
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   feed,
   input  logic [7:0]             rx_byte,
   output fpr_pkg::store_wr_type  store_wr,
   output fpr_pkg::parse_res_type parse_res
);

   localparam logic [16:0] DEPTH_W = 17'(PAYLOAD_DEPTH);

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_CMD_HI,
      ST_CMD_LO,
      ST_LEN_HI,
      ST_LEN_LO,
      ST_PAYLOAD,
      ST_SUM,
      ST_END
   } step_type;

   step_type    step_ff, step_in;
   logic [15:0] cmd_word_ff, cmd_word_in;
   logic [15:0] len_word_ff, len_word_in;
   logic [15:0] byte_count_ff, byte_count_in;
   logic [7:0]  running_sum_ff, running_sum_in;
   logic        trunc_ff, trunc_in;

   // Next state of the frame parser for one fed word.
   always_comb begin
      step_in        = step_ff;
      cmd_word_in    = cmd_word_ff;
      len_word_in    = len_word_ff;
      byte_count_in  = byte_count_ff;
      running_sum_in = running_sum_ff;
      trunc_in       = trunc_ff;
      store_wr.en    = 1'b0;
      store_wr.addr  = byte_count_ff;
      store_wr.data  = rx_byte;
      parse_res      = '{event_res: fpr_pkg::EV_NONE, frame_cmd: 16'd0, frame_len: 16'd0};
      if (feed) begin
         unique case (step_ff)
            ST_HUNT: begin
               if (rx_byte == fpr_pkg::START_BYTE) begin
                  step_in = ST_CMD_HI;
               end
            end
            ST_CMD_HI: begin
               cmd_word_in = {8'd0, rx_byte};
               step_in     = ST_CMD_LO;
            end
            ST_CMD_LO: begin
               cmd_word_in = {cmd_word_ff[7:0], rx_byte};
               step_in     = ST_LEN_HI;
            end
            ST_LEN_HI: begin
               len_word_in = {8'd0, rx_byte};
               step_in     = ST_LEN_LO;
            end
            ST_LEN_LO: begin
               len_word_in    = {len_word_ff[7:0], rx_byte};
               byte_count_in  = 16'd0;
               running_sum_in = 8'd0;
               trunc_in       = 1'b0;
               step_in        = ST_PAYLOAD;
            end
            ST_PAYLOAD: begin
               // Bytes past the end of the store only count toward the sum.
               running_sum_in = running_sum_ff + rx_byte;
               if ({1'b0, byte_count_ff} < DEPTH_W) begin
                  store_wr.en = 1'b1;
               end else begin
                  trunc_in = 1'b1;
               end
               byte_count_in = byte_count_ff + 16'd1;
               if (byte_count_in >= len_word_ff) begin
                  step_in = ST_SUM;
               end
            end
            ST_SUM: begin
               if (rx_byte == running_sum_ff) begin
                  step_in = ST_END;
               end else begin
                  parse_res = '{event_res: fpr_pkg::EV_SUM_ERR, frame_cmd: cmd_word_ff,
                                frame_len: len_word_ff};
                  step_in   = ST_HUNT;
               end
            end
            ST_END: begin
               parse_res.frame_cmd = cmd_word_ff;
               parse_res.frame_len = len_word_ff;
               if (rx_byte == fpr_pkg::END_BYTE) begin
                  parse_res.event_res = trunc_ff ? fpr_pkg::EV_OK_TRUNC : fpr_pkg::EV_OK;
               end else begin
                  parse_res.event_res = fpr_pkg::EV_BAD_END;
               end
               step_in = ST_HUNT;
            end
            default: begin
               step_in = ST_HUNT;
            end
         endcase
      end
   end

   // Parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff        <= ST_HUNT;
         cmd_word_ff    <= 16'd0;
         len_word_ff    <= 16'd0;
         byte_count_ff  <= 16'd0;
         running_sum_ff <= 8'd0;
         trunc_ff       <= 1'b0;
      end else begin
         step_ff        <= step_in;
         cmd_word_ff    <= cmd_word_in;
         len_word_ff    <= len_word_in;
         byte_count_ff  <= byte_count_in;
         running_sum_ff <= running_sum_in;
         trunc_ff       <= trunc_in;
      end
   end

   // A store write only happens inside the payload and never past the store.
   assert property (@(posedge clock) disable iff (reset)
      store_wr.en |-> (step_ff == ST_PAYLOAD) && ({1'b0, store_wr.addr} < DEPTH_W))
      else $error("payload store written outside the payload");

   // Leaving the payload always lands on the sum byte.
   assert property (@(posedge clock) disable iff (reset)
      feed && (step_ff == ST_PAYLOAD) && (byte_count_in >= len_word_ff) |=> step_ff == ST_SUM)
      else $error("payload did not end on the sum byte");

endmodule

// ===== rtl/fpr_rsp_queue.sv =====
module fpr_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fpr_pkg::rsp_type push_data,
   input  logic             pop,
   output fpr_pkg::rsp_type head,
   output logic [1:0]       count
);

   localparam int PW = (fpr_pkg::QUEUE_DEPTH > 1) ? $clog2(fpr_pkg::QUEUE_DEPTH) : 1;

   fpr_pkg::rsp_type entry_ff [fpr_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [1:0]       count_ff;

   // Entry storage, no reset needed.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assign head  = entry_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule
